// ===== hw/rtl/plob_pkg.sv =====
// ----------------------------------------------------------------------------
// plob_pkg
// Shared widths, field positions and codes of the price level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int LevelsDef  = 4096;
  localparam int QtyBitsDef = 32;

  localparam int TICK_W = 12;
  localparam int QTY_W  = 32;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 128;

  localparam int IN_SIDE_BIT = 0;
  localparam int IN_TICK_LSB = 1;
  localparam int IN_QTY_LSB  = 13;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef enum logic [1:0] {
    LVL_NONE = 2'd0,
    LVL_ASK  = 2'd1,
    LVL_BID  = 2'd2
  } lvl_side_e;

endpackage

// ===== hw/rtl/price_level_order_book.sv =====
// ----------------------------------------------------------------------------
// price_level_order_book
// Per-tick resting quantity store with best ask and best bid tracking.
//
//  channel  dir  tdata                                   tuser
//  s_axis   in   side, price_tick, quantity (48 bits)    func
//  m_axis   out  best_ask_tick, best_ask_qty,            -
//                best_bid_tick, best_bid_qty,
//                level_qty, level_side (128 bits)
//
// An update runs through the EXEC and DONE steps after accept, and a lookup
// through EXEC, LOOK and DONE; deleting a best level adds a SCAN step that
// walks the store one tick a cycle to the next resting level or the book end.
// After reset the store is cleared one tick a cycle with
// s_axis_tready low. A result word waiting on m_axis does not block s_axis;
// the next word runs and holds at its final step until the output frees.
// ----------------------------------------------------------------------------
module price_level_order_book #(
  parameter int LEVELS   = plob_pkg::LevelsDef,
  parameter int QTY_BITS = plob_pkg::QtyBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // side [0], price_tick [12:1], quantity [44:13], zero [47:45]
  input  logic [plob_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // func [0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // best_ask_tick [11:0], best_ask_qty [43:12], best_bid_tick [55:44],
  // best_bid_qty [87:56], level_qty [119:88], level_side [121:120], zero
  output logic [plob_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import plob_pkg::*;

  localparam int IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CMP_W = (IDX_W > TICK_W) ? IDX_W + 1 : TICK_W + 1;
  localparam logic [IDX_W-1:0] TopIdx = IDX_W'(LEVELS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_LOOK  = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic                func_q, side_q;
  logic [TICK_W-1:0]   tick_q;
  logic [QTY_BITS-1:0] qty_q;

  logic [IDX_W-1:0]    best_ask_q, best_ask_d, best_bid_q, best_bid_d;
  logic [QTY_BITS-1:0] ask_qty_q, ask_qty_d, bid_qty_q, bid_qty_d;
  logic [IDX_W-1:0]    walk_idx_q, walk_idx_d;
  logic                walk_up_q, walk_up_d;
  logic [QTY_W-1:0]    lvl_qty_q, lvl_qty_d;
  lvl_side_e           lvl_side_q, lvl_side_d;

  logic                    out_valid_q;
  logic [OUT_TDATA_W-1:0]  out_data_q;
  logic                    load_out;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [QTY_BITS-1:0] ram_wdata, ram_rdata;

  logic [IDX_W-1:0] step_idx, step_next;
  logic             step_up, step_at_bound;

  logic             s_accept;
  logic             in_range;
  logic [IDX_W-1:0] tick_idx;
  logic             is_ask;
  logic [IDX_W-1:0] upd_ask, upd_bid;
  logic             scan_ask, scan_bid;

  plob_ram #(
    .LEVELS   (LEVELS),
    .QTY_BITS (QTY_BITS),
    .IDX_W    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  plob_step #(
    .LEVELS (LEVELS),
    .IDX_W  (IDX_W)
  ) u_step (
    .idx_i      (step_idx),
    .up_i       (step_up),
    .next_o     (step_next),
    .at_bound_o (step_at_bound)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_range = CMP_W'(tick_q) < CMP_W'(LEVELS);
  assign tick_idx = IDX_W'(tick_q);
  assign is_ask   = (side_q == SIDE_ASK);

  assign step_idx = (state_q == ST_EXEC) ? tick_idx : walk_idx_q;
  assign step_up  = (state_q == ST_EXEC) ? is_ask : walk_up_q;

  assign upd_ask = (qty_q != '0 && is_ask && tick_idx < best_ask_q) ? tick_idx : best_ask_q;
  assign upd_bid = (qty_q != '0 && !is_ask && tick_idx > best_bid_q) ? tick_idx : best_bid_q;

  assign scan_ask = (qty_q == '0) && is_ask && (tick_idx == best_ask_q) && !step_at_bound;
  assign scan_bid = (qty_q == '0) && !is_ask && (tick_idx == best_bid_q) && !step_at_bound;

  always_comb begin
    state_d    = state_q;
    best_ask_d = best_ask_q;
    best_bid_d = best_bid_q;
    ask_qty_d  = ask_qty_q;
    bid_qty_d  = bid_qty_q;
    walk_idx_d = walk_idx_q;
    walk_up_d  = walk_up_q;
    lvl_qty_d  = lvl_qty_q;
    lvl_side_d = lvl_side_q;
    ram_we     = 1'b0;
    ram_waddr  = walk_idx_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = step_next;
    load_out   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (step_at_bound) begin
          state_d = ST_IDLE;
        end else begin
          walk_idx_d = step_next;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        lvl_qty_d  = '0;
        lvl_side_d = LVL_NONE;
        state_d    = ST_DONE;
        if (func_q == FUNC_LOOKUP) begin
          if (in_range) begin
            ram_re    = 1'b1;
            ram_raddr = tick_idx;
            state_d   = ST_LOOK;
          end
        end else if (in_range) begin
          ram_we     = 1'b1;
          ram_waddr  = tick_idx;
          ram_wdata  = qty_q;
          best_ask_d = upd_ask;
          best_bid_d = upd_bid;
          if (tick_idx == upd_ask) begin
            ask_qty_d = qty_q;
          end
          if (tick_idx == upd_bid) begin
            bid_qty_d = qty_q;
          end
          if (scan_ask || scan_bid) begin
            ram_re     = 1'b1;
            walk_idx_d = step_next;
            walk_up_d  = is_ask;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_LOOK: begin
        lvl_qty_d = QTY_W'(ram_rdata);
        if (ram_rdata == '0) begin
          lvl_side_d = LVL_NONE;
        end else if (tick_idx >= best_ask_q) begin
          lvl_side_d = LVL_ASK;
        end else if (tick_idx <= best_bid_q) begin
          lvl_side_d = LVL_BID;
        end else begin
          lvl_side_d = LVL_NONE;
        end
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (ram_rdata != '0 || step_at_bound) begin
          if (walk_up_q) begin
            best_ask_d = walk_idx_q;
            ask_qty_d  = ram_rdata;
          end else begin
            best_bid_d = walk_idx_q;
            bid_qty_d  = ram_rdata;
          end
          state_d = ST_DONE;
        end else begin
          ram_re     = 1'b1;
          walk_idx_d = step_next;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      best_ask_q  <= TopIdx;
      best_bid_q  <= '0;
      ask_qty_q   <= '0;
      bid_qty_q   <= '0;
      walk_idx_q  <= '0;
      walk_up_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      best_ask_q <= best_ask_d;
      best_bid_q <= best_bid_d;
      ask_qty_q  <= ask_qty_d;
      bid_qty_q  <= bid_qty_d;
      walk_idx_q <= walk_idx_d;
      walk_up_q  <= walk_up_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      func_q <= s_axis_tuser;
      side_q <= s_axis_tdata[IN_SIDE_BIT];
      tick_q <= s_axis_tdata[IN_TICK_LSB +: TICK_W];
      qty_q  <= QTY_BITS'(s_axis_tdata[IN_QTY_LSB +: QTY_W]);
    end
    lvl_qty_q  <= lvl_qty_d;
    lvl_side_q <= lvl_side_d;
    if (load_out) begin
      out_data_q <= {6'b0, lvl_side_q, lvl_qty_q,
                     QTY_W'(bid_qty_q), TICK_W'(best_bid_q),
                     QTY_W'(ask_qty_q), TICK_W'(best_ask_q)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/plob_ram.sv =====
// ----------------------------------------------------------------------------
// plob_ram
// Level quantity store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module plob_ram #(
  parameter int LEVELS   = 4096,
  parameter int QTY_BITS = 32,
  parameter int IDX_W    = $clog2(LEVELS)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  logic [QTY_BITS-1:0] wdata_i,
  input  logic                re_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output logic [QTY_BITS-1:0] rdata_o
);

  logic [QTY_BITS-1:0] mem [LEVELS];
  logic [QTY_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/plob_step.sv =====
// ----------------------------------------------------------------------------
// plob_step
// Shared tick walker: next index one tick up or down and end-of-book check.
// ----------------------------------------------------------------------------
module plob_step #(
  parameter int LEVELS = 4096,
  parameter int IDX_W  = $clog2(LEVELS)
) (
  input  logic [IDX_W-1:0] idx_i,
  input  logic             up_i,
  output logic [IDX_W-1:0] next_o,
  output logic             at_bound_o
);

  localparam logic [IDX_W-1:0] TopIdx = IDX_W'(LEVELS - 1);

  always_comb begin
    if (up_i) begin
      next_o     = idx_i + IDX_W'(1);
      at_bound_o = (idx_i == TopIdx);
    end else begin
      next_o     = idx_i - IDX_W'(1);
      at_bound_o = (idx_i == '0);
    end
  end

endmodule
